[rtl/dmc_pkg.sv]
// package for the door motor controller
// payload structs, phase and command codes, register indexes and reset values
// no dependencies
package dmc_pkg;

	// configuration port widths and register indexes
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 20;
	localparam int DEBOUNCE_W  = 16;
	localparam int TIMEOUT_W   = 20;

	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TRAVEL_TIMEOUT = 2'd1;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 20'd5000;

	// button positions in the debounce bank
	localparam int BTN_OPEN  = 0;
	localparam int BTN_CLOSE = 1;
	localparam int BTN_STOP  = 2;
	localparam int NUM_BTN   = 3;

	typedef enum logic [1:0] {
		PH_CLOSED  = 2'd0,
		PH_OPENING = 2'd1,
		PH_OPENED  = 2'd2,
		PH_CLOSING = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		HOLD_STOP  = 2'd0,
		HOLD_OPEN  = 2'd1,
		HOLD_CLOSE = 2'd2
	} cmd_t;

	typedef struct packed {
		logic       open_button_level;
		logic       close_button_level;
		logic       stop_button_level;
		logic       sw_cmd_valid;
		logic [1:0] sw_cmd;
	} dmc_in_t;

	typedef struct packed {
		logic       drive_cw;
		logic       drive_ccw;
		logic       drive_brake;
		logic [1:0] door_phase;
		logic [1:0] held_command;
	} dmc_out_t;

endpackage

[rtl/door_motor_controller_unit.sv]
// door motor controller: debounce, held command, door phase machine, travel timer
// one tick per input transfer, result registered on the output channel
// depends on dmc_pkg
// latency: a result is valid the cycle after its input transfer
// throughput: one tick per cycle while the output channel is not stalled, set by the single output register
// in_ready is high whenever the output register is empty or being taken
// reset (arst_n low): door closed, command stop, timer idle, buttons released,
// debounce_ticks 50, travel_timeout_ticks 5000, output channel empty
module door_motor_controller_unit
	import dmc_pkg::*;
#(
	parameter int TIMER_BITS    = 20,
	parameter int DEBOUNCE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  dmc_in_t                in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output dmc_out_t               out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CMPW = (DEBOUNCE_BITS > DEBOUNCE_W) ? DEBOUNCE_BITS : DEBOUNCE_W;
	localparam int TEXT = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

	// configuration registers
	logic [DEBOUNCE_W-1:0] debounce_q;
	logic [TIMEOUT_W-1:0]  timeout_q;

	// door and timer state
	phase_t                  phase_q, phase_n;
	cmd_t                    command_q, command_n;
	logic [TIMER_BITS-1:0]   remaining_q, remaining_n;
	logic                    running_q, running_n;
	logic                    expired_q, expired_n;

	// debounce bank
	logic [NUM_BTN-1:0]      last_q, last_n;
	logic [NUM_BTN-1:0]      latched_q, latched_n;
	logic [DEBOUNCE_BITS-1:0] cnt_q [NUM_BTN];
	logic [DEBOUNCE_BITS-1:0] cnt_n [NUM_BTN];

	// helpers
	logic                    accept;
	logic [NUM_BTN-1:0]      raw;
	logic [CMPW-1:0]         limit;
	logic [CMPW-1:0]         dt_ext;
	logic [CMPW-1:0]         dmax_ext;
	logic [TEXT-1:0]         timeout_ext;
	logic [TIMER_BITS-1:0]   timer_load;
	logic                    start;
	cmd_t                    cmd_mid;
	dmc_out_t                result;
	logic                    out_valid_q;
	dmc_out_t                out_q;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	assign raw[BTN_OPEN]  = in_data.open_button_level;
	assign raw[BTN_CLOSE] = in_data.close_button_level;
	assign raw[BTN_STOP]  = in_data.stop_button_level;

	// debounce limit clamped to the counter maximum
	assign dt_ext   = CMPW'(debounce_q);
	assign dmax_ext = CMPW'({DEBOUNCE_BITS{1'b1}});
	assign limit    = (dt_ext > dmax_ext) ? dmax_ext : dt_ext;

	// timer load value masked to the timer width
	assign timeout_ext = TEXT'(timeout_q);
	assign timer_load  = timeout_ext[TIMER_BITS-1:0];

	// software command ahead of the door machine
	always_comb begin
		cmd_mid = command_q;
		if (in_data.sw_cmd_valid && (in_data.sw_cmd <= HOLD_CLOSE)) begin
			cmd_mid = cmd_t'(in_data.sw_cmd);
		end
	end

	// next state: door machine, travel timer, debounce, command priority
	always_comb begin
		phase_n     = phase_q;
		remaining_n = remaining_q;
		running_n   = running_q;
		expired_n   = expired_q;
		start       = 1'b0;

		case (phase_q)
			PH_CLOSED: begin
				if (cmd_mid == HOLD_OPEN) begin
					start   = 1'b1;
					phase_n = PH_OPENING;
				end
			end
			PH_OPENING: begin
				if (cmd_mid == HOLD_CLOSE) begin
					start   = 1'b1;
					phase_n = PH_CLOSING;
				end else if (expired_q) begin
					phase_n   = PH_OPENED;
					expired_n = 1'b0;
				end
			end
			PH_OPENED: begin
				if (cmd_mid == HOLD_CLOSE) begin
					start   = 1'b1;
					phase_n = PH_CLOSING;
				end
			end
			default: begin
				if (cmd_mid == HOLD_OPEN) begin
					start   = 1'b1;
					phase_n = PH_OPENING;
				end else if (expired_q) begin
					phase_n   = PH_CLOSED;
					expired_n = 1'b0;
				end
			end
		endcase

		// timer start, then the same tick's countdown
		if (start) begin
			remaining_n = timer_load;
			running_n   = 1'b1;
			expired_n   = 1'b0;
		end
		if (running_n) begin
			if (remaining_n <= TIMER_BITS'(1)) begin
				remaining_n = '0;
				running_n   = 1'b0;
				expired_n   = 1'b1;
			end else begin
				remaining_n = remaining_n - TIMER_BITS'(1);
			end
		end

		// per-button stable-time counters
		for (int b = 0; b < NUM_BTN; b++) begin
			last_n[b]    = last_q[b];
			latched_n[b] = latched_q[b];
			cnt_n[b]     = cnt_q[b];
			if (raw[b] != last_q[b]) begin
				last_n[b] = raw[b];
				cnt_n[b]  = '0;
			end else begin
				if (cnt_q[b] != {DEBOUNCE_BITS{1'b1}}) begin
					cnt_n[b] = cnt_q[b] + DEBOUNCE_BITS'(1);
				end
				if (CMPW'(cnt_n[b]) >= limit) begin
					latched_n[b] = !raw[b];
				end
			end
		end

		// latched buttons override, stop first
		command_n = cmd_mid;
		if (latched_n[BTN_STOP]) begin
			command_n = HOLD_STOP;
		end else if (latched_n[BTN_OPEN]) begin
			command_n = HOLD_OPEN;
		end else if (latched_n[BTN_CLOSE]) begin
			command_n = HOLD_CLOSE;
		end
	end

	// outputs: motor pins follow the updated phase
	always_comb begin
		result.drive_cw     = (phase_n == PH_OPENING);
		result.drive_ccw    = (phase_n == PH_CLOSING);
		result.drive_brake  = (phase_n == PH_CLOSED) || (phase_n == PH_OPENED);
		result.door_phase   = phase_n;
		result.held_command = command_n;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			timeout_q  <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE_TICKS: debounce_q <= cfg_data[DEBOUNCE_W-1:0];
				REG_TRAVEL_TIMEOUT: timeout_q  <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// state update on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CLOSED;
			command_q   <= HOLD_STOP;
			remaining_q <= '0;
			running_q   <= 1'b0;
			expired_q   <= 1'b0;
			last_q      <= '1;
			latched_q   <= '0;
			for (int b = 0; b < NUM_BTN; b++) begin
				cnt_q[b] <= '0;
			end
		end else if (accept) begin
			phase_q     <= phase_n;
			command_q   <= command_n;
			remaining_q <= remaining_n;
			running_q   <= running_n;
			expired_q   <= expired_n;
			last_q      <= last_n;
			latched_q   <= latched_n;
			for (int b = 0; b < NUM_BTN; b++) begin
				cnt_q[b] <= cnt_n[b];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

`ifndef SYNTH
	// exactly one motor pin active on a pending result
	a_drive_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({out_data.drive_cw, out_data.drive_ccw, out_data.drive_brake}))
		else $error("motor drive pins not one-hot");

	// a running timer never carries a pending expiry
	a_run_not_expired: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> !expired_q)
		else $error("timer running with expiry flag set");

	// a door at rest has no travel timer running
	a_rest_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CLOSED || phase_q == PH_OPENED) |-> !running_q)
		else $error("travel timer running while door at rest");

	// an empty output register never stalls the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output register empty");
`endif

endmodule

[tb/door_motor_controller_unit_tb.sv]
// testbench for door_motor_controller_unit: directed and random ticks with a tick-level predictor
// drives the tick, result and register write channels, checks every result transfer in order
// depends on dmc_pkg and door_motor_controller_unit
`timescale 1ns / 1ps

module door_motor_controller_unit_tb;
	import dmc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	// spare register indexes, writes to them must be ignored
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	// software command code with no meaning
	localparam logic [1:0] SW_CMD_UNUSED = 2'd3;

	// button masks, bit positions follow the debounce bank
	localparam logic [NUM_BTN-1:0] PRESS_NONE  = '0;
	localparam logic [NUM_BTN-1:0] PRESS_OPEN  = NUM_BTN'(1 << BTN_OPEN);
	localparam logic [NUM_BTN-1:0] PRESS_CLOSE = NUM_BTN'(1 << BTN_CLOSE);
	localparam logic [NUM_BTN-1:0] PRESS_STOP  = NUM_BTN'(1 << BTN_STOP);
	localparam logic [NUM_BTN-1:0] PRESS_ALL   = '1;

	typedef enum logic [1:0] {
		MOTOR_IDLE = 2'd0,
		MOTOR_FWD  = 2'd1,
		MOTOR_REV  = 2'd2
	} motor_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	dmc_in_t                in_data = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	dmc_out_t               out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// idling controls shared with the driving processes
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_off_left = 0;
	int unsigned mismatches = 0;
	int unsigned cycles_run = 0;

	// predicted door state and register copies
	logic [DEBOUNCE_W-1:0] debounce_limit;
	logic [TIMEOUT_W-1:0]  travel_timeout;
	phase_t                door;
	motor_t                motor;
	cmd_t                  held;
	logic [TIMEOUT_W-1:0]  travel_left;
	logic                  travel_on;
	logic                  travel_done;
	logic [NUM_BTN-1:0]    last_level;
	logic [NUM_BTN-1:0]    latched;
	logic [DEBOUNCE_W-1:0] stable_cnt [NUM_BTN];

	dmc_out_t awaited_outputs [$];
	dmc_out_t head_output;

	door_motor_controller_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("door_motor_controller_unit_tb: FAIL");
		$finish;
	end

	// door state after reset
	function automatic void reset_door_model();
		debounce_limit = DEBOUNCE_RESET;
		travel_timeout = TIMEOUT_RESET;
		door = PH_CLOSED;
		motor = MOTOR_IDLE;
		held = HOLD_STOP;
		travel_left = '0;
		travel_on = 1'b0;
		travel_done = 1'b0;
		last_level = '1;
		latched = '0;
		for (int b = 0; b < NUM_BTN; b++) stable_cnt[b] = '0;
	endfunction

	// load the one-shot travel timer
	function automatic void start_travel();
		travel_left = travel_timeout;
		travel_on = 1'b1;
		travel_done = 1'b0;
	endfunction

	// one tick of the door: command, phase machine, timer, debounce
	function automatic dmc_out_t advance_door(input dmc_in_t t);
		dmc_out_t           r;
		logic [NUM_BTN-1:0] raw;
		raw[BTN_OPEN] = t.open_button_level;
		raw[BTN_CLOSE] = t.close_button_level;
		raw[BTN_STOP] = t.stop_button_level;

		if (t.sw_cmd_valid && t.sw_cmd <= HOLD_CLOSE) held = cmd_t'(t.sw_cmd);

		case (door)
			PH_CLOSED: begin
				if (held == HOLD_OPEN) begin
					start_travel();
					motor = MOTOR_FWD;
					door = PH_OPENING;
				end
			end
			PH_OPENING: begin
				if (held == HOLD_CLOSE) begin
					start_travel();
					motor = MOTOR_REV;
					door = PH_CLOSING;
				end else if (travel_done) begin
					motor = MOTOR_IDLE;
					door = PH_OPENED;
					travel_done = 1'b0;
				end
			end
			PH_OPENED: begin
				if (held == HOLD_CLOSE) begin
					start_travel();
					motor = MOTOR_REV;
					door = PH_CLOSING;
				end
			end
			default: begin
				if (held == HOLD_OPEN) begin
					start_travel();
					motor = MOTOR_FWD;
					door = PH_OPENING;
				end else if (travel_done) begin
					motor = MOTOR_IDLE;
					door = PH_CLOSED;
					travel_done = 1'b0;
				end
			end
		endcase

		// timer counts down, a zero load expires on the first tick
		if (travel_on) begin
			if (travel_left <= 1) begin
				travel_left = '0;
				travel_on = 1'b0;
				travel_done = 1'b1;
			end else begin
				travel_left--;
			end
		end

		// debounce, latch follows once the level has been stable long enough
		for (int b = 0; b < NUM_BTN; b++) begin
			if (raw[b] != last_level[b]) begin
				last_level[b] = raw[b];
				stable_cnt[b] = '0;
			end else begin
				if (stable_cnt[b] != '1) stable_cnt[b]++;
				if (stable_cnt[b] >= debounce_limit) latched[b] = !raw[b];
			end
		end

		if (latched[BTN_STOP]) held = HOLD_STOP;
		else if (latched[BTN_OPEN]) held = HOLD_OPEN;
		else if (latched[BTN_CLOSE]) held = HOLD_CLOSE;

		r.drive_cw = (motor == MOTOR_FWD);
		r.drive_ccw = (motor == MOTOR_REV);
		r.drive_brake = (motor == MOTOR_IDLE);
		r.door_phase = door;
		r.held_command = held;
		return r;
	endfunction

	function automatic dmc_in_t make_tick(input logic [NUM_BTN-1:0] pressed, input logic swv,
			input logic [1:0] sw);
		dmc_in_t t;
		t.open_button_level = !pressed[BTN_OPEN];
		t.close_button_level = !pressed[BTN_CLOSE];
		t.stop_button_level = !pressed[BTN_STOP];
		t.sw_cmd_valid = swv;
		t.sw_cmd = sw;
		return t;
	endfunction

	// offer one tick, with random idle cycles ahead of it, and predict its result
	task automatic send_tick(input dmc_in_t t);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		awaited_outputs.push_back(advance_door(t));
	endtask

	task automatic send_ticks(input int n, input logic [NUM_BTN-1:0] pressed, input logic swv,
			input logic [1:0] sw);
		repeat (n) send_tick(make_tick(pressed, swv, sw));
	endtask

	// stop offering and wait until every result transfer has been seen
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_outputs.size() != 0) @(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_DEBOUNCE_TICKS) debounce_limit = val[DEBOUNCE_W-1:0];
		else if (idx == REG_TRAVEL_TIMEOUT) travel_timeout = val[TIMEOUT_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result channel stalls and the long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_left != 0) begin
				out_ready <= 1'b0;
				hold_off_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_outputs.size() == 0) begin
				$error("result transfer with nothing awaited");
				mismatches++;
			end else begin
				head_output = awaited_outputs.pop_front();
				check_field("drive_cw", 2'(head_output.drive_cw), 2'(out_data.drive_cw));
				check_field("drive_ccw", 2'(head_output.drive_ccw), 2'(out_data.drive_ccw));
				check_field("drive_brake", 2'(head_output.drive_brake),
					2'(out_data.drive_brake));
				check_field("door_phase", head_output.door_phase, out_data.door_phase);
				check_field("held_command", head_output.held_command, out_data.held_command);
			end
		end
	end

	// reset values: open held long enough to pass the default debounce time
	task automatic test_reset_defaults();
		send_ticks(2, PRESS_NONE, 1'b0, HOLD_STOP);
		send_ticks(52, PRESS_OPEN, 1'b0, HOLD_STOP);
		send_ticks(2, PRESS_NONE, 1'b0, HOLD_STOP);
	endtask

	// largest register values, upper data bits masked, spare indexes ignored
	task automatic test_register_extremes();
		write_reg(REG_DEBOUNCE_TICKS, '1);
		write_reg(REG_TRAVEL_TIMEOUT, '1);
		write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
		send_ticks(1, PRESS_NONE, 1'b1, HOLD_CLOSE);
		send_ticks(1, PRESS_NONE, 1'b1, HOLD_OPEN);
		send_ticks(1, PRESS_NONE, 1'b1, HOLD_STOP);
		send_ticks(1, PRESS_NONE, 1'b1, SW_CMD_UNUSED);
		send_ticks(3, PRESS_STOP, 1'b0, HOLD_STOP);
	endtask

	// zero debounce and zero timeout, full open and close with the unused code
	task automatic test_zero_settings();
		write_reg(REG_DEBOUNCE_TICKS, '0);
		write_reg(REG_TRAVEL_TIMEOUT, '0);
		send_ticks(3, PRESS_NONE, 1'b0, HOLD_STOP);
		send_ticks(1, PRESS_NONE, 1'b1, HOLD_CLOSE);
		send_ticks(3, PRESS_NONE, 1'b1, SW_CMD_UNUSED);
		send_ticks(1, PRESS_NONE, 1'b1, HOLD_OPEN);
		send_ticks(3, PRESS_NONE, 1'b0, HOLD_STOP);
	endtask

	// button priority, reversal mid-travel and a bouncing button
	task automatic test_button_priority();
		write_reg(REG_DEBOUNCE_TICKS, CFG_DATA_W'(2));
		write_reg(REG_TRAVEL_TIMEOUT, CFG_DATA_W'(4));
		send_ticks(4, PRESS_ALL, 1'b1, HOLD_OPEN);
		send_ticks(4, PRESS_OPEN | PRESS_CLOSE, 1'b0, HOLD_STOP);
		send_ticks(5, PRESS_CLOSE, 1'b1, HOLD_OPEN);
		repeat (3) begin
			send_ticks(1, PRESS_OPEN, 1'b0, HOLD_STOP);
			send_ticks(1, PRESS_NONE, 1'b0, HOLD_STOP);
		end
		send_ticks(6, PRESS_NONE, 1'b0, HOLD_STOP);
	endtask

	// result channel held off long enough to fill the block and stall the tick channel
	task automatic test_output_backpressure();
		hold_off_left = 300;
		repeat (40) send_tick(make_tick(NUM_BTN'($urandom), 1'($urandom_range(1)),
			2'($urandom)));
	endtask

	// button episodes with bounce, occasional software commands and some noise
	task automatic run_random_phase(input int n_ticks);
		logic [NUM_BTN-1:0] held_down;
		logic [NUM_BTN-1:0] now_down;
		dmc_in_t            t;
		held_down = '0;
		repeat (n_ticks) begin
			for (int b = 0; b < NUM_BTN; b++) begin
				if (held_down[b]) begin
					if ($urandom_range(99) < 15) held_down[b] = 1'b0;
				end else if ($urandom_range(99) < ((b == BTN_STOP) ? 2 : 5)) begin
					held_down[b] = 1'b1;
				end
			end
			now_down = held_down;
			if ($urandom_range(99) < 3) now_down[$urandom_range(NUM_BTN-1)] ^= 1'b1;
			t = make_tick(now_down, ($urandom_range(99) < 12), 2'($urandom));
			if ($urandom_range(99) < 8) t = 6'($urandom);
			send_tick(t);
		end
	endtask

	// random phases across register settings and idling patterns
	task automatic test_random_traffic();
		for (int p = 0; p < 8; p++) begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
			write_reg(REG_DEBOUNCE_TICKS, {4'($urandom), 16'($urandom_range(6))});
			write_reg(REG_TRAVEL_TIMEOUT, CFG_DATA_W'($urandom_range(24)));
			if ($urandom_range(1)) write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
				CFG_DATA_W'($urandom));
			case (p / 2)
				1: send_idle_pct = 66;
				2: recv_stall_pct = 66;
				3: begin
					send_idle_pct = 10;
					recv_stall_pct = 10;
				end
				default: ;
			endcase
			run_random_phase(200);
		end
	endtask

	// test sequence
	initial begin
		reset_door_model();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_register_extremes();
		test_zero_settings();
		test_button_priority();
		test_output_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("door_motor_controller_unit_tb: PASS");
		end else begin
			$display("door_motor_controller_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
